@@ src/tsli_pkg.sv @@
package tsli_pkg;

    // Field widths
    localparam int TIME_W     = 32;
    localparam int SPEED_W    = 16;
    localparam int IDX_W      = 12;
    localparam int POINTS_W   = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int SRC_W      = 2;

    // Interpolation fixed point
    localparam int FRAC_W     = 16;
    localparam int DIFF_W     = SPEED_W + 1;
    localparam int PROD_W     = FRAC_W + 2 + DIFF_W;
    localparam int SUM_W      = PROD_W - FRAC_W;
    localparam int DIV_CNT_W  = $clog2(FRAC_W);
    localparam logic [FRAC_W:0] FRAC_ONE = {1'b1, {FRAC_W{1'b0}}};

    // Commands
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Result source codes
    localparam logic [SRC_W-1:0] SRC_INTERP = 2'd0;
    localparam logic [SRC_W-1:0] SRC_FIRST  = 2'd1;
    localparam logic [SRC_W-1:0] SRC_LAST   = 2'd2;
    localparam logic [SRC_W-1:0] SRC_MEAN   = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MEAN   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_POINTS = 2'd3;

endpackage

@@ src/tsli_ram.sv @@
module tsli_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ src/time_series_linear_interpolator.sv @@
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_stall    command, point_index, time_value, point_speed
// out       output     out_valid / out_stall  speed_value, speed_source
// cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item at a time. A load writes the table directly; a disabled or mean-only query
// goes straight to the emit state. A query clamped at a table end reads entry 0 and
// then, if needed, entry n-1; an interpolated query also runs a binary search with one
// table read per search step on the single read port, and a 16-step restoring divider.
// Reset clears control and configuration; the table is not cleared.
// A stalled result holds in the output register; the next item is taken meanwhile.
module time_series_linear_interpolator #(
    parameter int TABLE_DEPTH = 4096  // 2 .. 4096
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // input items
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               command,
    input  logic [tsli_pkg::IDX_W-1:0]         point_index,
    input  logic [tsli_pkg::TIME_W-1:0]        time_value,
    input  logic signed [tsli_pkg::SPEED_W-1:0] point_speed,
    // results
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [tsli_pkg::SPEED_W-1:0] speed_value,
    output logic [tsli_pkg::SRC_W-1:0]         speed_source,
    // configuration writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tsli_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tsli_pkg::CFG_DATA_W-1:0]    cfg_data
);

    import tsli_pkg::*;

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int RAM_W  = TIME_W + SPEED_W;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_FIRST  = 10'b0000000010,
        S_LAST   = 10'b0000000100,
        S_SEARCH = 10'b0000001000,
        S_RD0    = 10'b0000010000,
        S_RD1    = 10'b0000100000,
        S_DIV    = 10'b0001000000,
        S_MUL    = 10'b0010000000,
        S_FIN    = 10'b0100000000,
        S_EMIT   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic                      cfg_enable_reg;
    logic                      cfg_mode_reg;
    logic signed [SPEED_W-1:0] cfg_mean_reg;
    logic [POINTS_W-1:0]       cfg_points_reg;

    // query working registers
    logic [TIME_W-1:0]         q_reg, q_next;
    logic [CNT_W-1:0]          n_reg, n_next;
    logic [CNT_W-1:0]          lo_reg, lo_next;
    logic [CNT_W-1:0]          hi_reg, hi_next;
    logic [CNT_W-1:0]          mid_reg, mid_next;
    logic [TIME_W-1:0]         t0_reg, t0_next;
    logic signed [SPEED_W-1:0] s0_reg, s0_next;
    logic signed [DIFF_W-1:0]  diff_reg, diff_next;
    logic [TIME_W-1:0]         rem_reg, rem_next;
    logic [TIME_W-1:0]         div_reg, div_next;
    logic [FRAC_W-1:0]         quot_reg, quot_next;
    logic [DIV_CNT_W-1:0]      cnt_reg, cnt_next;
    logic [FRAC_W:0]           frac_reg, frac_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [SPEED_W-1:0] res_speed_reg, res_speed_next;
    logic [SRC_W-1:0]          res_src_reg, res_src_next;

    // output register
    logic                      out_valid_reg, out_valid_next;
    logic signed [SPEED_W-1:0] out_speed_reg, out_speed_next;
    logic [SRC_W-1:0]          out_src_reg, out_src_next;

    // table memory
    logic                      ram_wr_en;
    logic                      ram_rd_en;
    logic [ADDR_W-1:0]         ram_rd_addr;
    logic [RAM_W-1:0]          ram_rd_data;
    logic [TIME_W-1:0]         rd_time;
    logic signed [SPEED_W-1:0] rd_speed;

    logic                      in_xfer;
    logic                      out_free;
    logic [POINTS_W-1:0]       points_sat;

    assign rd_time  = ram_rd_data[RAM_W-1:SPEED_W];
    assign rd_speed = $signed(ram_rd_data[SPEED_W-1:0]);

    assign in_stall  = (state_reg != S_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;

    assign out_valid    = out_valid_reg;
    assign speed_value  = out_speed_reg;
    assign speed_source = out_src_reg;

    assign points_sat = (cfg_points_reg > POINTS_W'(TABLE_DEPTH)) ?
                        POINTS_W'(TABLE_DEPTH) : cfg_points_reg;

    // Load items write the table directly; index beyond the depth is dropped
    assign ram_wr_en = in_xfer && (command == CMD_LOAD) &&
                       ({1'b0, point_index} < (IDX_W + 1)'(TABLE_DEPTH));

    tsli_ram #(
        .WIDTH (RAM_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (point_index[ADDR_W-1:0]),
        .wr_data ({time_value, point_speed}),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_enable_reg <= 1'b0;
            cfg_mode_reg   <= 1'b0;
            cfg_mean_reg   <= '0;
            cfg_points_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_ENABLE: cfg_enable_reg <= cfg_data[0];
                CFG_MODE:   cfg_mode_reg   <= cfg_data[0];
                CFG_MEAN:   cfg_mean_reg   <= $signed(cfg_data[SPEED_W-1:0]);
                CFG_POINTS: cfg_points_reg <= cfg_data[POINTS_W-1:0];
            endcase
        end
    end

    // Query sequencer: end checks, binary search, divide, multiply
    always_comb
    begin
        logic [CNT_W-1:0]  srch_lo;
        logic [CNT_W-1:0]  srch_hi;
        logic [CNT_W-1:0]  srch_mid;
        logic [CNT_W-1:0]  lo_fix;
        logic [TIME_W:0]   rem_shift;
        logic              quot_bit;
        logic signed [SUM_W-1:0] sum;

        state_next     = state_reg;
        q_next         = q_reg;
        n_next         = n_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        t0_next        = t0_reg;
        s0_next        = s0_reg;
        diff_next      = diff_reg;
        rem_next       = rem_reg;
        div_next       = div_reg;
        quot_next      = quot_reg;
        cnt_next       = cnt_reg;
        frac_next      = frac_reg;
        prod_next      = prod_reg;
        res_speed_next = res_speed_reg;
        res_src_next   = res_src_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_speed_next = out_speed_reg;
        out_src_next   = out_src_reg;
        ram_rd_en      = 1'b0;
        ram_rd_addr    = '0;
        srch_lo        = lo_reg;
        srch_hi        = hi_reg;
        srch_mid       = '0;
        lo_fix         = '0;
        rem_shift      = '0;
        quot_bit       = 1'b0;
        sum            = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer && (command == CMD_QUERY))
                begin
                    q_next = time_value;
                    n_next = points_sat[CNT_W-1:0];
                    if (!cfg_enable_reg)
                    begin
                        res_speed_next = '0;
                        res_src_next   = SRC_MEAN;
                        state_next     = S_EMIT;
                    end
                    else if (!cfg_mode_reg || (cfg_points_reg == '0))
                    begin
                        res_speed_next = cfg_mean_reg;
                        res_src_next   = SRC_MEAN;
                        state_next     = S_EMIT;
                    end
                    else
                    begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = '0;
                        state_next  = S_FIRST;
                    end
                end
            end

            // entry 0 on the read port
            S_FIRST:
            begin
                if (q_reg <= rd_time)
                begin
                    res_speed_next = rd_speed;
                    res_src_next   = SRC_FIRST;
                    state_next     = S_EMIT;
                end
                else
                begin
                    lo_fix      = n_reg - CNT_W'(1);
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = lo_fix[ADDR_W-1:0];
                    state_next  = S_LAST;
                end
            end

            // entry n-1 on the read port
            S_LAST:
            begin
                if (q_reg >= rd_time)
                begin
                    res_speed_next = rd_speed;
                    res_src_next   = SRC_LAST;
                    state_next     = S_EMIT;
                end
                else
                begin
                    srch_mid    = n_reg >> 1;
                    lo_next     = '0;
                    hi_next     = n_reg;
                    mid_next    = srch_mid;
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = srch_mid[ADDR_W-1:0];
                    state_next  = S_SEARCH;
                end
            end

            // one search step per cycle: narrow, then read the next midpoint
            S_SEARCH:
            begin
                if (rd_time < q_reg)
                begin
                    srch_lo = mid_reg + CNT_W'(1);
                end
                else
                begin
                    srch_hi = mid_reg;
                end
                lo_next = srch_lo;
                hi_next = srch_hi;
                if (srch_lo < srch_hi)
                begin
                    srch_mid    = srch_lo + ((srch_hi - srch_lo) >> 1);
                    mid_next    = srch_mid;
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = srch_mid[ADDR_W-1:0];
                end
                else
                begin
                    // keep the segment index within 1..n-1
                    lo_fix = srch_lo;
                    if (lo_fix >= n_reg)
                    begin
                        lo_fix = n_reg - CNT_W'(1);
                    end
                    if (lo_fix == '0)
                    begin
                        lo_fix = CNT_W'(1);
                    end
                    lo_next     = lo_fix;
                    srch_mid    = lo_fix - CNT_W'(1);
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = srch_mid[ADDR_W-1:0];
                    state_next  = S_RD0;
                end
            end

            // lower point of the segment
            S_RD0:
            begin
                t0_next     = rd_time;
                s0_next     = rd_speed;
                ram_rd_en   = 1'b1;
                ram_rd_addr = lo_reg[ADDR_W-1:0];
                state_next  = S_RD1;
            end

            // upper point: pick the fraction or start the divide
            S_RD1:
            begin
                diff_next = DIFF_W'(rd_speed) - DIFF_W'(s0_reg);
                if ((rd_time <= t0_reg) || (q_reg <= t0_reg))
                begin
                    frac_next  = '0;
                    state_next = S_MUL;
                end
                else if (q_reg >= rd_time)
                begin
                    frac_next  = FRAC_ONE;
                    state_next = S_MUL;
                end
                else
                begin
                    rem_next   = q_reg - t0_reg;
                    div_next   = rd_time - t0_reg;
                    quot_next  = '0;
                    cnt_next   = DIV_CNT_W'(FRAC_W - 1);
                    state_next = S_DIV;
                end
            end

            // restoring divide, one quotient bit per cycle
            S_DIV:
            begin
                rem_shift = {rem_reg, 1'b0};
                if (rem_shift >= {1'b0, div_reg})
                begin
                    quot_bit = 1'b1;
                    rem_shift = rem_shift - {1'b0, div_reg};
                end
                rem_next  = rem_shift[TIME_W-1:0];
                quot_next = {quot_reg[FRAC_W-2:0], quot_bit};
                if (cnt_reg == '0)
                begin
                    frac_next  = {1'b0, quot_next};
                    state_next = S_MUL;
                end
                else
                begin
                    cnt_next = cnt_reg - DIV_CNT_W'(1);
                end
            end

            S_MUL:
            begin
                prod_next  = $signed({1'b0, frac_reg}) * diff_reg;
                state_next = S_FIN;
            end

            // floor shift of the product, added to the lower speed
            S_FIN:
            begin
                sum            = $signed(prod_reg[PROD_W-1:FRAC_W]) + SUM_W'(s0_reg);
                res_speed_next = sum[SPEED_W-1:0];
                res_src_next   = SRC_INTERP;
                state_next     = S_EMIT;
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_speed_next = res_speed_reg;
                    out_src_next   = res_src_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        q_reg         <= q_next;
        n_reg         <= n_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        mid_reg       <= mid_next;
        t0_reg        <= t0_next;
        s0_reg        <= s0_next;
        diff_reg      <= diff_next;
        rem_reg       <= rem_next;
        div_reg       <= div_next;
        quot_reg      <= quot_next;
        cnt_reg       <= cnt_next;
        frac_reg      <= frac_next;
        prod_reg      <= prod_next;
        res_speed_reg <= res_speed_next;
        res_src_reg   <= res_src_next;
        out_speed_reg <= out_speed_next;
        out_src_reg   <= out_src_next;
    end

    // Search window stays open and inside the table
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH) |-> ((lo_reg < hi_reg) && (hi_reg <= n_reg)
                                     && (mid_reg >= lo_reg) && (mid_reg < hi_reg)))
        else $error("search window out of bounds");

    // Segment index is within 1..n-1 once the search ends
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD0) |-> ((lo_reg != '0) && (lo_reg < n_reg)))
        else $error("segment index out of range");

    // Divider remainder stays below the interval
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (rem_reg < div_reg))
        else $error("divider remainder not below divisor");

    // A new result only follows the emit state
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !$past(out_valid_reg && out_stall)) |->
            ($past(state_reg) == S_EMIT))
        else $error("result appeared without emit");

    // The table is not written while a query is in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !ram_wr_en)
        else $error("table written during a query");

endmodule

@@ verif/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tsli_pkg::*;

    localparam int DEPTH         = 4096;
    localparam int SETTLE_CYCLES = 64;
    localparam int MAX_REPORTS   = 10;

    typedef longint unsigned u64_t;

    typedef struct packed {
        logic signed [SPEED_W-1:0] speed;
        logic [SRC_W-1:0]          source;
    } speed_answer_t;

    typedef enum int {TBL_WIDE, TBL_NARROW, TBL_DUPS, TBL_SCRAMBLED} table_style_t;

    // Mirror of the lookup table and registers; predicts one answer per query
    class speed_scoreboard;
        bit [TIME_W-1:0]          time_tab [DEPTH];
        bit signed [SPEED_W-1:0]  speed_tab [DEPTH];
        bit                       enabled;
        bit                       series;
        bit signed [SPEED_W-1:0]  mean;
        bit [POINTS_W-1:0]        points;
        speed_answer_t            answers_due [$];
        int                       faults;

        function void write_register(logic [CFG_IDX_W-1:0] index,
                                     logic [CFG_DATA_W-1:0] data);
            case (index)
                CFG_ENABLE: enabled = data[0];
                CFG_MODE:   series  = data[0];
                CFG_MEAN:   mean    = data;
                CFG_POINTS: points  = data[POINTS_W-1:0];
                default: ;
            endcase
        endfunction

        // Linear blend between entries i-1 and i, fraction in 0..65536
        function logic signed [SPEED_W-1:0] blend(int unsigned i, u64_t q);
            u64_t   t0;
            u64_t   t1;
            u64_t   frac;
            longint s0;
            longint s1;
            longint prod;
            t0 = u64_t'(time_tab[i-1]);
            t1 = u64_t'(time_tab[i]);
            s0 = speed_tab[i-1];
            s1 = speed_tab[i];
            if (t1 <= t0 || q <= t0)
                frac = 0;
            else if (q >= t1)
                frac = 65536;
            else
                frac = ((q - t0) << 16) / (t1 - t0);
            prod = longint'(frac) * (s1 - s0);
            // arithmetic shift floors toward minus infinity
            return SPEED_W'(s0 + (prod >>> 16));
        endfunction

        function speed_answer_t speed_at(logic [TIME_W-1:0] query_time);
            int unsigned   n;
            int unsigned   lo;
            int unsigned   hi;
            int unsigned   mid;
            u64_t          q;
            speed_answer_t a;
            q = u64_t'(query_time);
            a.speed  = '0;
            a.source = SRC_MEAN;
            if (!enabled)
                return a;
            if (!series || points == 0) begin
                a.speed = mean;
                return a;
            end
            // point count saturates at the table depth
            n = (points > DEPTH) ? DEPTH : int'(points);
            if (q <= u64_t'(time_tab[0])) begin
                a.speed  = speed_tab[0];
                a.source = SRC_FIRST;
                return a;
            end
            if (q >= u64_t'(time_tab[n-1])) begin
                a.speed  = speed_tab[n-1];
                a.source = SRC_LAST;
                return a;
            end
            // first entry at or after the query time
            lo = 0;
            hi = n;
            while (lo < hi) begin
                mid = lo + (hi - lo) / 2;
                if (u64_t'(time_tab[mid]) < q)
                    lo = mid + 1;
                else
                    hi = mid;
            end
            if (lo >= n)
                lo = n - 1;
            if (lo == 0)
                lo = 1;
            a.speed  = blend(lo, q);
            a.source = SRC_INTERP;
            return a;
        endfunction

        function void record_item(logic cmd, logic [IDX_W-1:0] idx,
                                  logic [TIME_W-1:0] t, logic signed [SPEED_W-1:0] spd);
            if (cmd == CMD_LOAD) begin
                time_tab[idx]  = t;
                speed_tab[idx] = spd;
            end else begin
                answers_due.insert(answers_due.size(), speed_at(t));
            end
        endfunction

        function void check_answer(logic signed [SPEED_W-1:0] speed,
                                   logic [SRC_W-1:0] source);
            speed_answer_t want;
            if (answers_due.size() == 0) begin
                faults++;
                if (faults <= MAX_REPORTS)
                    $display("%0t: unexpected speed result %0d src %0d",
                             $realtime, speed, source);
                return;
            end
            want = answers_due.pop_front();
            if (speed !== want.speed || source !== want.source) begin
                faults++;
                if (faults <= MAX_REPORTS)
                    $display("%0t: speed mismatch: expected %0d src %0d, got %0d src %0d",
                             $realtime, want.speed, want.source, speed, source);
            end
        endfunction

        function int pending();
            return answers_due.size();
        endfunction
    endclass

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_stall;
    logic                        command;
    logic [IDX_W-1:0]            point_index;
    logic [TIME_W-1:0]           time_value;
    logic signed [SPEED_W-1:0]   point_speed;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic signed [SPEED_W-1:0]   speed_value;
    logic [SRC_W-1:0]            speed_source;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [CFG_IDX_W-1:0]        cfg_index;
    logic [CFG_DATA_W-1:0]       cfg_data;

    speed_scoreboard sb;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int items_sent     = 0;
    int table_len      = 0;

    time_series_linear_interpolator i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .point_index  (point_index),
        .time_value   (time_value),
        .point_speed  (point_speed),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .speed_value  (speed_value),
        .speed_source (speed_source),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #30_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Result side: random stall, check every transfer
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_answer(speed_value, speed_source);
    end

    // One input transfer, with random idle cycles ahead of it
    task automatic send_item(logic cmd, logic [IDX_W-1:0] idx,
                             logic [TIME_W-1:0] t, logic signed [SPEED_W-1:0] spd);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        command     <= cmd;
        point_index <= idx;
        time_value  <= t;
        point_speed <= spd;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.record_item(cmd, idx, t, spd);
        items_sent++;
    endtask

    task automatic load_point(int idx, logic [TIME_W-1:0] t, logic signed [SPEED_W-1:0] spd);
        send_item(CMD_LOAD, IDX_W'(idx), t, spd);
    endtask

    // Unused index and speed fields carry random bits on queries
    task automatic query(logic [TIME_W-1:0] t);
        send_item(CMD_QUERY, IDX_W'($urandom), t, SPEED_W'($urandom));
    endtask

    // Hold the input side until every answer is back, then wait extra cycles
    task automatic drain(int extra);
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_register(idx, data);
    endtask

    // Registers change only with the block idle
    task automatic configure(logic en, logic mode, logic signed [SPEED_W-1:0] mean_spd,
                             logic [POINTS_W-1:0] n_points);
        drain(SETTLE_CYCLES);
        write_reg(CFG_ENABLE, CFG_DATA_W'(en));
        write_reg(CFG_MODE, CFG_DATA_W'(mode));
        write_reg(CFG_MEAN, mean_spd);
        write_reg(CFG_POINTS, CFG_DATA_W'(n_points));
        cfg_valid <= 1'b0;
    endtask

    // Fill entries 0..n-1; times stay inside 32 bits for the ascending styles
    task automatic build_table(int n, table_style_t style);
        u64_t step_max;
        u64_t t;
        if (style == TBL_WIDE)
            step_max = 64'hFFFF_FFFF / u64_t'(n > 0 ? n : 1);
        else
            step_max = u64_t'($urandom_range(1, 40));
        t = u64_t'($urandom) % (64'h1_0000_0000 - step_max * u64_t'(n));
        for (int i = 0; i < n; i++) begin
            if (style == TBL_SCRAMBLED)
                t = u64_t'($urandom);
            else if (i > 0 && !(style == TBL_DUPS && $urandom_range(0, 2) == 0))
                t += 1 + (u64_t'($urandom) % step_max);
            load_point(i, TIME_W'(t), SPEED_W'($urandom));
        end
        table_len = n;
    endtask

    // Query times near points, between neighbors, at the ends, or anywhere
    function automatic logic [TIME_W-1:0] pick_time();
        int   i;
        u64_t lo_t;
        u64_t hi_t;
        if (table_len == 0)
            return TIME_W'($urandom);
        i    = int'($urandom_range(0, table_len - 1));
        lo_t = u64_t'(sb.time_tab[i]);
        hi_t = (i + 1 < table_len) ? u64_t'(sb.time_tab[i+1]) : lo_t;
        case ($urandom_range(0, 9)) inside
            [0:1]:   return TIME_W'(lo_t);
            2:       return TIME_W'(lo_t + 1);
            3:       return TIME_W'(lo_t - 1);
            [4:6]:   return (hi_t > lo_t) ?
                            TIME_W'(lo_t + (u64_t'($urandom) % (hi_t - lo_t))) : TIME_W'(lo_t);
            [7:8]:   return TIME_W'($urandom);
            default: return $urandom_range(0, 1) ? '1 : '0;
        endcase
    endfunction

    task automatic directed_checks();
        // disabled right after reset
        query('0);
        // mean only, at both extremes
        configure(1'b1, 1'b0, 16'sh8000, 13'd0);
        query('1);
        configure(1'b1, 1'b0, 16'sh7FFF, 13'd3);
        query(TIME_W'($urandom));
        // series mode with an empty table
        configure(1'b1, 1'b1, 16'sh1234, 13'd0);
        query(TIME_W'($urandom));
        // three points with extreme speeds, last point at the top of time
        load_point(0, 32'd1000, 16'sh8000);
        load_point(1, 32'd2000, 16'sh7FFF);
        load_point(2, 32'hFFFF_FFFF, 16'sh0000);
        table_len = 3;
        configure(1'b1, 1'b1, 16'sh0000, 13'd3);
        query(32'd0);
        query(32'd1000);
        query(32'd1001);
        query(32'd1500);
        query(32'd1999);
        query(32'd2000);
        query(32'd2001);
        query(32'hFFFF_FFFE);
        query(32'hFFFF_FFFF);
        // single point: only the end values
        configure(1'b1, 1'b1, 16'sh0000, 13'd1);
        query(32'd500);
        query(32'd5000);
        // disabled with a loaded table
        configure(1'b0, 1'b1, 16'sh4000, 13'd3);
        query(32'd1500);
    endtask

    task automatic random_phase();
        int                        n;
        int                        sel;
        int                        idx;
        logic signed [SPEED_W-1:0] mean_spd;
        sel = int'($urandom_range(0, 9));
        if (sel == 0)
            n = 0;
        else if (sel == 1)
            n = 1;
        else if (sel == 2)
            n = 2;
        else if (sel < 8)
            n = int'($urandom_range(3, 16));
        else
            n = int'($urandom_range(17, 80));
        sel = int'($urandom_range(0, 3));
        mean_spd = (sel == 0) ? 16'sh8000 : (sel == 1) ? 16'sh7FFF : SPEED_W'($urandom);
        configure($urandom_range(0, 9) != 0, $urandom_range(0, 5) != 0, mean_spd,
                  POINTS_W'(n));
        build_table(n, table_style_t'($urandom_range(0, 3)));
        // mostly queries, some loads rewriting live or spare entries
        repeat (30) begin
            if ($urandom_range(0, 99) < 20) begin
                if (table_len > 0 && $urandom_range(0, 1) == 1)
                    idx = int'($urandom_range(0, table_len - 1));
                else
                    idx = int'($urandom_range(0, DEPTH - 1));
                load_point(idx, pick_time(), SPEED_W'($urandom));
            end else begin
                query(pick_time());
            end
            // every 37th item, the sender holds off until all answers are back
            if (items_sent % 37 == 0)
                drain(0);
        end
    endtask

    initial
    begin
        int mark;
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        command     <= CMD_LOAD;
        point_index <= '0;
        time_value  <= '0;
        point_speed <= '0;
        cfg_valid   <= 1'b0;
        cfg_index   <= CFG_ENABLE;
        cfg_data    <= '0;
        sb = new;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct  = 31;
        recv_stall_pct = 87;
        directed_checks();

        // three idling regimes over the random part
        for (int r = 0; r < 3; r++) begin
            send_idle_pct  = (r == 0) ? 31 : (r == 1) ? 87 : 0;
            recv_stall_pct = (r == 0) ? 87 : (r == 1) ? 31 : 0;
            mark = items_sent;
            while (items_sent < mark + 140)
                random_phase();
        end

        // point count at and above the depth: only the two end entries are
        // loaded, so every query stays at or beyond an end
        configure(1'b1, 1'b1, 16'sh0000, 13'd0);
        load_point(0, 32'd100, SPEED_W'($urandom));
        load_point(DEPTH - 1, 32'd200, SPEED_W'($urandom));
        table_len = 0;
        configure(1'b1, 1'b1, 16'sh0000, 13'd8191);
        query(32'd50);
        query(32'd100);
        query(32'd200);
        query('1);
        configure(1'b1, 1'b1, 16'sh0000, 13'd4097);
        query(32'd100);
        query(32'd300);
        configure(1'b1, 1'b1, 16'sh0000, 13'd4096);
        query(32'd0);
        query(32'd200);

        drain(SETTLE_CYCLES);
        if (sb.faults == 0 && sb.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ sim.f @@
src/tsli_pkg.sv
src/tsli_ram.sv
src/time_series_linear_interpolator.sv
verif/tb.sv
